// File: hdl/swst_pkg.sv
// Shared types and constants for the single-wire UART/SIF transmitter.
package swst_pkg;

    // Message buffer geometry.
    localparam int BUF_DEPTH = 256;
    localparam int BUF_AW    = $clog2(BUF_DEPTH);
    localparam int CNT_W     = $clog2(BUF_DEPTH + 1);

    // Configuration register indexes.
    localparam logic REG_UART_TICKS = 1'b0;
    localparam logic REG_SIF_TICKS  = 1'b1;

    // Input word kinds.
    typedef enum logic [1:0] {
        KIND_LOAD       = 2'd0,
        KIND_START_UART = 2'd1,
        KIND_START_SIF  = 2'd2,
        KIND_TICK       = 2'd3
    } t_kind;

    // Configuration values seen by the sequencer.
    typedef struct packed {
        logic [7:0] sif_ticks;
        logic [7:0] uart_ticks;
    } t_cfg;

    // One result word, line level in the lowest bit.
    typedef struct packed {
        logic error;
        logic link_ok;
        logic done_res;
        logic busy_res;
        logic line_out;
    } t_result;

endpackage

// File: hdl/swst_buf.sv
// Message byte store: one write port, one registered read port.
module swst_buf
    import swst_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [BUF_AW-1:0] i_wr_addr,
    input  logic [7:0]        i_wr_data,
    input  logic [BUF_AW-1:0] i_rd_addr,
    output logic [7:0]        o_rd_data
);

    logic [7:0] r_mem [BUF_DEPTH];
    logic [7:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hdl/swst_seq.sv
// Send sequencer: message bookkeeping, UART and SIF line coding, readback check.
module swst_seq
    import swst_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  t_kind      i_kind,
    input  logic [7:0] i_data_byte,
    input  logic       i_bus_level,
    input  t_cfg       i_cfg,
    output t_result    o_res
);

    typedef enum logic [2:0] {
        PH_IDLE, PH_START, PH_LOW, PH_HIGH, PH_STOP, PH_ERR
    } t_phase;

    typedef enum logic [1:0] {
        MODE_NONE, MODE_UART, MODE_SIF
    } t_mode;

    t_phase           r_phase, n_phase;
    t_mode            r_mode, n_mode;
    logic [7:0]       r_tick, n_tick;
    logic [3:0]       r_bit, n_bit;
    logic [CNT_W-1:0] r_byte, n_byte;
    logic [CNT_W-1:0] r_load, n_load;
    logic [CNT_W-1:0] r_len, n_len;
    logic             r_line, n_line;
    logic             r_conn, n_conn;

    logic             wr_en;
    logic [7:0]       cur_byte;
    logic             busy;
    logic             done;
    logic             err;
    logic [7:0]       tick_inc;
    logic [3:0]       bit_inc;
    logic [CNT_W-1:0] byte_inc;
    logic             sif_bit;
    logic [7:0]       low_len;
    logic [7:0]       high_len;

    // Byte store, read at the byte index of the coming cycle.
    swst_buf u_buf (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_load[BUF_AW-1:0]),
        .i_wr_data (i_data_byte),
        .i_rd_addr (n_byte[BUF_AW-1:0]),
        .o_rd_data (cur_byte)
    );

    assign busy     = (r_phase != PH_IDLE);
    assign tick_inc = r_tick + 8'd1;
    assign bit_inc  = r_bit + 4'd1;
    assign byte_inc = r_byte + CNT_W'(1);
    // SIF sends MSB first: bit 7 - index is the inverted index.
    assign sif_bit  = cur_byte[~r_bit[2:0]];
    assign low_len  = sif_bit ? 8'd1 : 8'd2;
    assign high_len = sif_bit ? 8'd2 : 8'd1;

    // Next state for one accepted word.
    always_comb begin
        n_phase = r_phase;
        n_mode  = r_mode;
        n_tick  = r_tick;
        n_bit   = r_bit;
        n_byte  = r_byte;
        n_load  = r_load;
        n_len   = r_len;
        n_line  = r_line;
        n_conn  = r_conn;
        wr_en   = 1'b0;
        done    = 1'b0;
        err     = 1'b0;
        if (i_take) begin
            case (i_kind)
                KIND_LOAD: begin
                    if (!busy && (r_load < CNT_W'(BUF_DEPTH))) begin
                        wr_en  = 1'b1;
                        n_load = r_load + CNT_W'(1);
                    end
                end
                KIND_START_UART, KIND_START_SIF: begin
                    if (!busy && (r_load != '0)) begin
                        n_len   = r_load;
                        n_load  = '0;
                        n_byte  = '0;
                        n_bit   = '0;
                        n_tick  = '0;
                        n_phase = PH_START;
                        n_mode  = (i_kind == KIND_START_UART) ? MODE_UART : MODE_SIF;
                    end
                end
                default: begin
                    if (busy && (r_mode == MODE_UART)) begin
                        // UART: start, eight data bits LSB first, stop.
                        n_tick = tick_inc;
                        case (r_phase)
                            PH_START: begin
                                n_line = 1'b0;
                                if (tick_inc >= i_cfg.uart_ticks) begin
                                    n_phase = PH_LOW;
                                    n_tick  = '0;
                                    n_bit   = '0;
                                end
                            end
                            PH_LOW: begin
                                n_line = cur_byte[r_bit[2:0]];
                                if (tick_inc >= i_cfg.uart_ticks) begin
                                    n_tick = '0;
                                    n_bit  = bit_inc;
                                    if (bit_inc >= 4'd8) begin
                                        n_phase = PH_STOP;
                                        n_byte  = byte_inc;
                                    end
                                end
                            end
                            default: begin
                                n_line = 1'b1;
                                if (tick_inc >= i_cfg.uart_ticks) begin
                                    n_tick = '0;
                                    n_bit  = '0;
                                    if (r_byte < r_len) begin
                                        n_phase = PH_START;
                                    end else begin
                                        n_phase = PH_IDLE;
                                        n_mode  = MODE_NONE;
                                        n_byte  = '0;
                                        done    = 1'b1;
                                    end
                                end
                            end
                        endcase
                    end else if (busy) begin
                        // SIF: sync, pulse-width coded bits MSB first, closing low.
                        case (r_phase)
                            PH_START: begin
                                n_tick = tick_inc;
                                if (tick_inc >= i_cfg.sif_ticks) begin
                                    n_line  = 1'b1;
                                    n_phase = PH_LOW;
                                    n_tick  = '0;
                                    n_bit   = '0;
                                end else begin
                                    n_line = 1'b0;
                                end
                            end
                            PH_LOW: begin
                                if (!i_bus_level && (r_tick == '0)) begin
                                    // Bus held low by someone else: abort.
                                    n_phase = PH_ERR;
                                    n_conn  = 1'b0;
                                    err     = 1'b1;
                                end else begin
                                    n_conn = 1'b1;
                                    n_line = 1'b0;
                                    n_tick = tick_inc;
                                    if (tick_inc >= low_len) begin
                                        n_tick  = '0;
                                        n_phase = PH_HIGH;
                                    end
                                end
                            end
                            PH_HIGH: begin
                                n_line = 1'b1;
                                n_tick = tick_inc;
                                if (tick_inc >= high_len) begin
                                    n_tick = '0;
                                    if (bit_inc >= 4'd8) begin
                                        n_bit   = '0;
                                        n_byte  = byte_inc;
                                        n_phase = (byte_inc >= r_len) ? PH_STOP : PH_LOW;
                                    end else begin
                                        n_bit   = bit_inc;
                                        n_phase = (r_byte >= r_len) ? PH_STOP : PH_LOW;
                                    end
                                end
                            end
                            PH_STOP: begin
                                n_line = 1'b0;
                                n_tick = tick_inc;
                                if (tick_inc >= i_cfg.sif_ticks) begin
                                    n_tick  = '0;
                                    n_bit   = '0;
                                    n_byte  = '0;
                                    n_phase = PH_IDLE;
                                    n_mode  = MODE_NONE;
                                    done    = 1'b1;
                                end
                            end
                            default: begin
                                // Recovery after an abort.
                                n_line  = 1'b1;
                                n_tick  = '0;
                                n_bit   = '0;
                                n_byte  = '0;
                                n_phase = PH_IDLE;
                                n_mode  = MODE_NONE;
                                done    = 1'b1;
                            end
                        endcase
                    end
                end
            endcase
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_mode  <= MODE_NONE;
            r_tick  <= '0;
            r_bit   <= '0;
            r_byte  <= '0;
            r_load  <= '0;
            r_len   <= '0;
            r_line  <= 1'b1;
            r_conn  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_mode  <= n_mode;
            r_tick  <= n_tick;
            r_bit   <= n_bit;
            r_byte  <= n_byte;
            r_load  <= n_load;
            r_len   <= n_len;
            r_line  <= n_line;
            r_conn  <= n_conn;
        end
    end

    // Result word for the accepted input word.
    always_comb begin
        o_res.line_out = n_line;
        o_res.busy_res = (n_phase != PH_IDLE);
        o_res.done_res = done;
        o_res.link_ok  = n_conn;
        o_res.error    = err;
    end

endmodule

// File: hdl/single_wire_uart_sif_transmitter_unit.sv
// Top level: stream ports, configuration registers and result register.
//
//  Channel   Direction  Words
//  s_axis    in         tuser = kind; tdata = data_byte, bus_level
//  m_axis    out        tdata = line_out, busy_res, done_res, link_ok, error
//  APB       in/out     uart_bit_ticks at 0x0, sif_sync_ticks at 0x4
//
//  One input word is accepted per cycle while the output register can move on, and its
//  result word is in the output register in the next cycle; the sequencer state update is the only path.
//  A new word is taken while the output register is empty or being drained.
//  Reset is synchronous: idle, line high, link flag clear, ticks 4 and 40.
//  The message store is not cleared; only bytes loaded since the last start
//  are sent.
module single_wire_uart_sif_transmitter_unit
    import swst_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] data_byte, [8] bus_level
    input  logic [1:0]  s_axis_tuser,   // [1:0] kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [0] line_out, [1] busy_res, [2] done_res,
                                        // [3] link_ok, [4] error
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg    r_cfg;
    t_result res;
    t_result r_out_data;
    logic    r_out_valid;
    logic    take;
    logic    cfg_wr;

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.uart_ticks <= 8'd4;
            r_cfg.sif_ticks  <= 8'd40;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_UART_TICKS) begin
                r_cfg.uart_ticks <= pwdata[7:0];
            end else begin
                r_cfg.sif_ticks <= pwdata[7:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_SIF_TICKS) ? {24'd0, r_cfg.sif_ticks}
                                                 : {24'd0, r_cfg.uart_ticks};

    // Input handshake: take a word whenever the result register can move on.
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign take          = s_axis_tvalid && s_axis_tready;

    swst_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_kind      (t_kind'(s_axis_tuser)),
        .i_data_byte (s_axis_tdata[7:0]),
        .i_bus_level (s_axis_tdata[8]),
        .i_cfg       (r_cfg),
        .o_res       (res)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out_data <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'd0, r_out_data};

`ifndef NO_ASSERTIONS
    // A word taken always shows up in the result register next cycle.
    a_take_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |=> r_out_valid)
        else $error("accepted word did not reach the result register");

    // A held result blocks new input.
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input taken while result stalled");

    // A readback error keeps the send open and drops the link.
    a_err_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data.error) |-> (r_out_data.busy_res && !r_out_data.link_ok))
        else $error("error word with inconsistent busy or link");

    // A finished message is no longer busy.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data.done_res) |-> !r_out_data.busy_res)
        else $error("done word still busy");
`endif

endmodule

// File: tb/sv/tb_single_wire_uart_sif_transmitter_unit.sv
// Self-checking testbench for the single-wire UART/SIF transmitter unit.
`timescale 1ns / 1ps

module tb_single_wire_uart_sif_transmitter_unit;
    import swst_pkg::*;

    // Sequencer phases and line codes as tracked by the predictor.
    typedef enum logic [2:0] {
        TX_IDLE,
        TX_START,
        TX_BITS_LOW,
        TX_BITS_HIGH,
        TX_STOP,
        TX_ABORT
    } t_tx_phase;

    typedef enum logic [1:0] {
        SEND_NONE,
        SEND_UART,
        SEND_SIF
    } t_send_mode;

    // One input word before packing onto the stream.
    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic       bus;
    } t_tx_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;    // [7:0] data_byte, [8] bus_level
    logic [1:0]  s_axis_tuser = '0;    // [1:0] kind
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;         // [0] line_out, [1] busy_res, [2] done_res,
                                       // [3] link_ok, [4] error
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    single_wire_uart_sif_transmitter_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 i_clk = ~i_clk;

    // Predictor copy of the configuration and sequencer state.
    logic [7:0]   uart_ticks;
    logic [7:0]   sif_ticks;
    t_tx_phase    tx_phase;
    t_send_mode   tx_mode;
    logic [7:0]   tick_cnt;
    int           bit_idx;
    int           byte_idx;
    int           load_cnt;
    int           msg_len;
    logic [7:0]   msg_mem [0:BUF_DEPTH-1];
    logic         line_lvl;
    logic         linked;

    t_tx_word     tx_word_q[$];
    t_result      predicted_status_q[$];
    t_tx_word     drv_word;
    int           gap_left = 0;
    int           gap_limit = 0;
    int           words_sent = 0;
    int           stall_left = 0;
    int           stall_limit = 0;
    int           results_seen = 0;
    int           queued_words = 0;
    int           fail_cnt = 0;

    task automatic report_mismatch(string what, int got, int want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        fail_cnt++;
    endtask

    function automatic int pick_limit();
        case ($urandom_range(0, 2))
            0: return 0;
            1: return 3;
            default: return 14;
        endcase
    endfunction

    // One UART tick: start bit, eight data bits LSB first, stop bit.
    function automatic logic uart_step();
        logic fin;
        fin = 1'b0;
        tick_cnt = tick_cnt + 8'd1;
        case (tx_phase)
            TX_START: begin
                line_lvl = 1'b0;
                if (tick_cnt >= uart_ticks) begin
                    tx_phase = TX_BITS_LOW;
                    tick_cnt = '0;
                    bit_idx  = 0;
                end
            end
            TX_BITS_LOW: begin
                line_lvl = msg_mem[byte_idx][bit_idx];
                if (tick_cnt >= uart_ticks) begin
                    tick_cnt = '0;
                    bit_idx++;
                    if (bit_idx >= 8) begin
                        tx_phase = TX_STOP;
                        byte_idx++;
                    end
                end
            end
            default: begin
                line_lvl = 1'b1;
                if (tick_cnt >= uart_ticks) begin
                    tick_cnt = '0;
                    bit_idx  = 0;
                    if (byte_idx < msg_len) begin
                        tx_phase = TX_START;
                    end else begin
                        tx_phase = TX_IDLE;
                        tx_mode  = SEND_NONE;
                        byte_idx = 0;
                        fin      = 1'b1;
                    end
                end
            end
        endcase
        return fin;
    endfunction

    // One SIF tick: sync, pulse-width bits MSB first, closing low, readback abort.
    function automatic logic sif_step(input logic bus, output logic abort_flag);
        logic fin;
        logic bitv;
        fin = 1'b0;
        abort_flag = 1'b0;
        case (tx_phase)
            TX_START: begin
                tick_cnt = tick_cnt + 8'd1;
                if (tick_cnt >= sif_ticks) begin
                    line_lvl = 1'b1;
                    tx_phase = TX_BITS_LOW;
                    tick_cnt = '0;
                    bit_idx  = 0;
                end else begin
                    line_lvl = 1'b0;
                end
            end
            TX_BITS_LOW: begin
                bitv = msg_mem[byte_idx][7 - bit_idx];
                // The wire is read back only on the first tick of a low phase.
                if (bus == 1'b0 && tick_cnt == 8'd0) begin
                    tx_phase   = TX_ABORT;
                    linked     = 1'b0;
                    abort_flag = 1'b1;
                end else begin
                    linked   = 1'b1;
                    line_lvl = 1'b0;
                    tick_cnt = tick_cnt + 8'd1;
                    if (int'(tick_cnt) >= 2 - int'(bitv)) begin
                        tick_cnt = '0;
                        tx_phase = TX_BITS_HIGH;
                    end
                end
            end
            TX_BITS_HIGH: begin
                bitv = msg_mem[byte_idx][7 - bit_idx];
                line_lvl = 1'b1;
                tick_cnt = tick_cnt + 8'd1;
                if (int'(tick_cnt) >= 1 + int'(bitv)) begin
                    tick_cnt = '0;
                    bit_idx++;
                    if (bit_idx >= 8) begin
                        byte_idx++;
                        bit_idx = 0;
                    end
                    tx_phase = (byte_idx >= msg_len) ? TX_STOP : TX_BITS_LOW;
                end
            end
            TX_STOP: begin
                line_lvl = 1'b0;
                tick_cnt = tick_cnt + 8'd1;
                if (tick_cnt >= sif_ticks) begin
                    tick_cnt = '0;
                    bit_idx  = 0;
                    byte_idx = 0;
                    tx_phase = TX_IDLE;
                    tx_mode  = SEND_NONE;
                    fin      = 1'b1;
                end
            end
            default: begin
                line_lvl = 1'b1;
                tick_cnt = '0;
                bit_idx  = 0;
                byte_idx = 0;
                tx_phase = TX_IDLE;
                tx_mode  = SEND_NONE;
                fin      = 1'b1;
            end
        endcase
        return fin;
    endfunction

    // Advances the predictor by one accepted word and returns its status word.
    function automatic t_result advance_transmitter(t_tx_word w);
        logic    was_busy;
        logic    fin;
        logic    abort_flag;
        t_result r;
        was_busy   = (tx_phase != TX_IDLE);
        fin        = 1'b0;
        abort_flag = 1'b0;
        case (w.kind)
            KIND_LOAD: begin
                if (!was_busy && load_cnt < BUF_DEPTH) begin
                    msg_mem[load_cnt] = w.data;
                    load_cnt++;
                end
            end
            KIND_START_UART, KIND_START_SIF: begin
                if (!was_busy && load_cnt != 0) begin
                    msg_len  = load_cnt;
                    load_cnt = 0;
                    byte_idx = 0;
                    bit_idx  = 0;
                    tick_cnt = '0;
                    tx_phase = TX_START;
                    tx_mode  = (w.kind == KIND_START_UART) ? SEND_UART : SEND_SIF;
                end
            end
            default: begin
                if (was_busy) begin
                    if (tx_mode == SEND_UART) fin = uart_step();
                    else fin = sif_step(w.bus, abort_flag);
                end
            end
        endcase
        r.line_out = line_lvl;
        r.busy_res = (tx_phase != TX_IDLE);
        r.done_res = fin;
        r.link_ok  = linked;
        r.error    = abort_flag;
        return r;
    endfunction

    // Input side: presents queued words, predicts each one on acceptance.
    always @(posedge i_clk) begin : word_driver
        logic fire;
        fire = s_axis_tvalid && s_axis_tready;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            gap_left = 0;
        end else begin
            if (fire) predicted_status_q.push_back(advance_transmitter(drv_word));
            if (fire || !s_axis_tvalid) begin
                if (gap_left != 0) begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (tx_word_q.size() != 0) begin
                    drv_word = tx_word_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {7'd0, drv_word.bus, drv_word.data};
                    s_axis_tuser  <= drv_word.kind;
                    if (words_sent % 40 == 0) gap_limit = pick_limit();
                    words_sent++;
                    gap_left = $urandom_range(0, gap_limit);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Output side: checks each status word against the oldest prediction.
    always @(posedge i_clk) begin : result_monitor
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = t_result'(m_axis_tdata[4:0]);
                if (predicted_status_q.size() == 0) begin
                    report_mismatch("unexpected status word", int'(got), 0);
                end else begin
                    want = predicted_status_q.pop_front();
                    if (got.line_out != want.line_out)
                        report_mismatch("line_out", got.line_out, want.line_out);
                    if (got.busy_res != want.busy_res)
                        report_mismatch("busy_res", got.busy_res, want.busy_res);
                    if (got.done_res != want.done_res)
                        report_mismatch("done_res", got.done_res, want.done_res);
                    if (got.link_ok != want.link_ok)
                        report_mismatch("link_ok", got.link_ok, want.link_ok);
                    if (got.error != want.error)
                        report_mismatch("error", got.error, want.error);
                end
                if (results_seen % 40 == 0) stall_limit = pick_limit();
                results_seen++;
                stall_left = $urandom_range(0, stall_limit);
            end
            if (stall_left != 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic push_word(t_kind kind, logic [7:0] data, logic bus);
        t_tx_word w;
        w.kind = kind;
        w.data = data;
        w.bus  = bus;
        tx_word_q.push_back(w);
        queued_words++;
    endtask

    // One APB transfer; read data is taken mid access cycle.
    task automatic apb_cycle(input logic wr, input logic [2:0] addr, input logic [31:0] wdata,
                             output logic [31:0] rdata);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        rdata = prdata;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Writes a tick register, mirrors it in the predictor and reads it back.
    task automatic write_tick_reg(logic idx, logic [7:0] value);
        logic [31:0] rd;
        apb_cycle(1'b1, {idx, 2'b00}, {24'd0, value}, rd);
        if (idx == REG_UART_TICKS) uart_ticks = value;
        else sif_ticks = value;
        apb_cycle(1'b0, {idx, 2'b00}, '0, rd);
        if (rd != {24'd0, value}) report_mismatch("register readback", int'(rd), int'(value));
    endtask

    // Waits until every word is out and answered; flushes a send still running.
    task automatic settle_idle();
        forever begin
            @(negedge i_clk);
            while (tx_word_q.size() != 0 || s_axis_tvalid || predicted_status_q.size() != 0)
                @(negedge i_clk);
            if (tx_phase == TX_IDLE) break;
            repeat (64) push_word(KIND_TICK, 8'($urandom_range(0, 255)), 1'b1);
        end
        repeat (4) @(posedge i_clk);
    endtask

    // Loads a message, starts it and queues enough ticks to finish it.
    task automatic queue_message(t_kind start_kind, int len, bit noisy, bit meddle);
        int ticks;
        logic bus;
        for (int i = 0; i < len; i++)
            push_word(KIND_LOAD, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        push_word(start_kind, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        if (start_kind == KIND_START_UART)
            ticks = len * 10 * ((uart_ticks == 0) ? 1 : int'(uart_ticks));
        else
            ticks = 2 * ((sif_ticks == 0) ? 1 : int'(sif_ticks)) + 24 * len;
        ticks += $urandom_range(0, 3);
        for (int i = 0; i < ticks; i++) begin
            // Loads and starts during a send should be ignored.
            if (meddle && $urandom_range(0, 15) == 0)
                push_word(t_kind'($urandom_range(0, 2)), 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)));
            if (start_kind == KIND_START_UART) bus = 1'($urandom_range(0, 1));
            else bus = !(noisy && $urandom_range(0, 29) == 0);
            push_word(KIND_TICK, 8'($urandom_range(0, 255)), bus);
        end
    endtask

    initial begin : stimulus
        int phase_end;
        int len;
        uart_ticks = 8'd4;
        sif_ticks  = 8'd40;
        tx_phase   = TX_IDLE;
        tx_mode    = SEND_NONE;
        tick_cnt   = '0;
        bit_idx    = 0;
        byte_idx   = 0;
        load_cnt   = 0;
        msg_len    = 0;
        line_lvl   = 1'b1;
        linked     = 1'b0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Ticks while idle and starts with an empty buffer change nothing.
        push_word(KIND_TICK, 8'h00, 1'b0);
        push_word(KIND_TICK, 8'hFF, 1'b1);
        push_word(KIND_START_UART, 8'hFF, 1'b0);
        push_word(KIND_START_SIF, 8'h00, 1'b1);

        // UART send at reset timing, with a load and a start while busy.
        push_word(KIND_LOAD, 8'h00, 1'b0);
        push_word(KIND_LOAD, 8'hFF, 1'b1);
        push_word(KIND_START_UART, 8'h00, 1'b0);
        push_word(KIND_LOAD, 8'h5A, 1'b0);
        push_word(KIND_START_SIF, 8'h00, 1'b0);
        for (int i = 0; i < 2 * 10 * 4 + 2; i++) push_word(KIND_TICK, 8'h00, i[0]);

        // SIF send aborted by a low readback on the first bit; a low during sync is ignored.
        push_word(KIND_LOAD, 8'h3C, 1'b0);
        push_word(KIND_START_SIF, 8'h00, 1'b0);
        for (int i = 0; i < 40 + 3; i++) push_word(KIND_TICK, 8'h00, !(i == 5 || i == 40));
        settle_idle();

        // Largest tick counts are stored and read back.
        write_tick_reg(REG_UART_TICKS, 8'd255);
        write_tick_reg(REG_SIF_TICKS, 8'd255);

        // A zero tick count behaves as one.
        write_tick_reg(REG_UART_TICKS, 8'd0);
        write_tick_reg(REG_SIF_TICKS, 8'd0);
        queue_message(KIND_START_UART, 2, 1'b0, 1'b1);
        queue_message(KIND_START_SIF, 2, 1'b0, 1'b1);
        settle_idle();

        // Full buffer: loads past the depth are dropped; a low readback cuts the send short.
        write_tick_reg(REG_UART_TICKS, 8'd1);
        write_tick_reg(REG_SIF_TICKS, 8'd1);
        for (int i = 0; i < BUF_DEPTH + 2; i++) push_word(KIND_LOAD, 8'(i), 1'b1);
        push_word(KIND_START_SIF, 8'h00, 1'b0);
        push_word(KIND_TICK, 8'h00, 1'b1);
        push_word(KIND_TICK, 8'h00, 1'b0);
        push_word(KIND_TICK, 8'h00, 1'b1);
        settle_idle();

        // Random messages under two short timings, with stray words mixed in.
        for (int p = 0; p < 2; p++) begin
            write_tick_reg(REG_UART_TICKS, 8'($urandom_range(1, 4)));
            write_tick_reg(REG_SIF_TICKS, ($urandom_range(0, 3) == 0) ?
                           8'($urandom_range(1, 20)) : 8'($urandom_range(1, 4)));
            phase_end = queued_words + 40;
            while (queued_words < phase_end) begin
                if ($urandom_range(0, 7) == 0) begin
                    repeat ($urandom_range(1, 4))
                        push_word(t_kind'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                                  1'($urandom_range(0, 1)));
                end else begin
                    len = ($urandom_range(0, 9) == 0) ? $urandom_range(3, 6)
                                                      : $urandom_range(1, 2);
                    queue_message($urandom_range(0, 1) ? KIND_START_UART : KIND_START_SIF,
                                  len, $urandom_range(0, 2) == 0, 1'($urandom_range(0, 1)));
                end
            end
            settle_idle();
        end

        if (predicted_status_q.size() != 0)
            report_mismatch("status words never received", predicted_status_q.size(), 0);
        if (fail_cnt == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin : watchdog
        #20_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
